// ----- design/afs_pkg.sv -----
// Package for the activation frame stack.
// Holds sizes, codes, the frame header layout and the sequencer states.
// No dependencies.
`default_nettype none
package afs_pkg;
	localparam int MaxFrames = 64;
	localparam int MaxSlots = 64;
	localparam int OperandDepth = 256;
	localparam int ValueWidth = 32;
	localparam int HeaderSize = 3;
	localparam int FrameIdxW = $clog2(MaxFrames);
	localparam int SlotIdxW = $clog2(MaxSlots);
	localparam int OperandIdxW = $clog2(OperandDepth);

	typedef enum logic [3:0] {
		MODE_CLEAR = 4'd0,
		MODE_RESERVE = 4'd1,
		MODE_READ = 4'd2,
		MODE_WRITE = 4'd3,
		MODE_PUSH = 4'd4,
		MODE_POP = 4'd5,
		MODE_PEEK = 4'd6,
		MODE_CALL = 4'd7,
		MODE_RETURN = 4'd8
	} mode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_UNDER = 3'd1,
		ST_OVER = 3'd2,
		ST_CORRUPT = 3'd3,
		ST_INVALID = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_EXEC, S_WALK, S_MARK, S_OPND, S_RES, S_RET, S_FIN, S_LOAD
	} state_t;

	typedef struct packed {
		logic [5:0]  level;
		logic [6:0]  static_link;
		logic [6:0]  dynamic_link;
		logic [16:0] ret;
		logic [6:0]  size;
		logic [8:0]  base;
	} header_t;

	localparam int HeaderW = $bits(header_t);
endpackage
`default_nettype wire

// ----- design/afs_ram.sv -----
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`default_nettype none
module afs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic                     we,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- design/activation_frame_stack.sv -----
// Top level of the activation frame stack.
// Uses afs_pkg and four afs_ram instances (headers, slots, slot marks, operands).
`default_nettype none
// One instruction per item; in_stall holds off new items until it is done.
// Clear, push, a reserve that creates the global frame and errors found at once
// go from execute to finish and load. Pop, peek, return and a reserve in an
// existing frame pass an operand, return or reserve state first. Call, read and
// write walk d static links, where d is the level difference: each static link
// step is one read of the frame header memory. The result is held in an output
// register while the next item runs; a later result waits until that one is taken.
module activation_frame_stack
	import afs_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [3:0]         mode,
	input  wire logic signed [6:0]  level_difference,
	input  wire logic [6:0]         slot_offset,
	input  wire logic [6:0]         slot_count,
	input  wire logic signed [31:0] data_in,
	input  wire logic [15:0]        return_address,
	input  wire logic [8:0]         argument_count,
	input  wire logic [7:0]         peek_depth,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [2:0]              status,
	output logic signed [31:0]      data_out,
	output logic [6:0]              frames_in_use,
	output logic [8:0]              operands_in_use,
	output logic signed [16:0]      frame_return_address,
	output logic [8:0]              frame_operand_base,
	output logic [5:0]              frame_lexical_level,
	output logic signed [6:0]       frame_static_link,
	output logic signed [6:0]       frame_dynamic_link,
	output logic [6:0]              frame_slot_count
);
	state_t state_q, state_n;
	logic [6:0] limit_q, depth_q, depth_n;
	logic [8:0] top_q, top_n;
	logic [3:0] mode_q;
	logic [6:0] diff_q, off_q, cnt_q;
	logic [31:0] data_q, dout_q, dout_n;
	logic [15:0] ret_q;
	logic [8:0] args_q;
	logic [7:0] pdep_q;
	logic [5:0] idx_q, idx_n, walk_q, walk_n, pf_q, pf_n;
	logic popped_q, popped_n, have_q, have_n;
	status_t st_q, st_n;
	logic [MaxFrames-1:0] row_ok_q;
	logic row_clr, row_set;
	logic [5:0] row_idx;
	logic out_valid_q;
	logic load_en;
	logic [6:0] lim;

	logic [FrameIdxW-1:0] hdr_addr;
	logic hdr_we;
	header_t hdr_wdata, hdr_rdata;
	logic [FrameIdxW+SlotIdxW-1:0] slot_addr;
	logic slot_we;
	logic [31:0] slot_rdata;
	logic [FrameIdxW-1:0] mark_addr;
	logic mark_we;
	logic [MaxSlots-1:0] mark_wdata, mark_rdata, mark_row;
	logic [OperandIdxW-1:0] opnd_addr;
	logic opnd_we;
	logic [31:0] opnd_rdata;

	afs_ram #(.WIDTH(HeaderW), .DEPTH(MaxFrames)) u_hdr (
		.clk(clk), .addr(hdr_addr), .we(hdr_we), .wdata(hdr_wdata), .rdata(hdr_rdata)
	);
	afs_ram #(.WIDTH(ValueWidth), .DEPTH(MaxFrames * MaxSlots)) u_slot (
		.clk(clk), .addr(slot_addr), .we(slot_we), .wdata(data_q), .rdata(slot_rdata)
	);
	afs_ram #(.WIDTH(MaxSlots), .DEPTH(MaxFrames)) u_mark (
		.clk(clk), .addr(mark_addr), .we(mark_we), .wdata(mark_wdata), .rdata(mark_rdata)
	);
	afs_ram #(.WIDTH(ValueWidth), .DEPTH(OperandDepth)) u_opnd (
		.clk(clk), .addr(opnd_addr), .we(opnd_we), .wdata(data_q), .rdata(opnd_rdata)
	);

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {25'd0, limit_q} : 32'd0;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign load_en = (state_q == S_LOAD) && (!out_valid_q || !out_stall);
	assign mark_row = row_ok_q[idx_q] ? mark_rdata : '0;

	always_comb begin
		lim = limit_q;
		if (limit_q == 7'd0) begin
			lim = 7'd1;
		end else if (limit_q > 7'(MaxFrames)) begin
			lim = 7'(MaxFrames);
		end
	end

	always_comb begin
		state_n = state_q;
		depth_n = depth_q;
		top_n = top_q;
		dout_n = dout_q;
		idx_n = idx_q;
		walk_n = walk_q;
		pf_n = pf_q;
		popped_n = popped_q;
		have_n = have_q;
		st_n = st_q;
		row_clr = 1'b0;
		row_set = 1'b0;
		row_idx = idx_q;
		hdr_addr = idx_q;
		hdr_we = 1'b0;
		hdr_wdata = hdr_rdata;
		slot_addr = {idx_q, off_q[5:0]};
		slot_we = 1'b0;
		mark_addr = idx_q;
		mark_we = 1'b0;
		mark_wdata = mark_row | (MaxSlots'(1) << off_q[5:0]);
		opnd_addr = top_q[7:0];
		opnd_we = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					state_n = S_EXEC;
					st_n = ST_OK;
					dout_n = '0;
					popped_n = 1'b0;
				end
			end
			S_EXEC: begin
				state_n = S_FIN;
				case (mode_q)
					MODE_CLEAR: begin
						depth_n = '0;
						top_n = '0;
					end
					MODE_RESERVE: begin
						if (cnt_q < 7'(HeaderSize)) begin
							st_n = ST_CORRUPT;
						end else if (cnt_q > 7'(MaxSlots)) begin
							st_n = ST_OVER;
						end else if (depth_q == 7'd0) begin
							hdr_addr = '0;
							hdr_we = 1'b1;
							hdr_wdata = '{level: '0, static_link: '1, dynamic_link: '1,
								ret: '1, size: cnt_q, base: '0};
							row_clr = 1'b1;
							row_idx = '0;
							depth_n = 7'd1;
						end else begin
							hdr_addr = 6'(depth_q - 7'd1);
							state_n = S_RES;
						end
					end
					MODE_READ, MODE_WRITE, MODE_CALL: begin
						if (mode_q == MODE_CALL && depth_q >= lim) begin
							st_n = ST_OVER;
						end else if (mode_q == MODE_CALL && args_q > top_q) begin
							st_n = ST_CORRUPT;
						end else if (depth_q == 7'd0) begin
							st_n = ST_UNDER;
						end else if (diff_q[6]) begin
							st_n = ST_INVALID;
						end else begin
							idx_n = 6'(depth_q - 7'd1);
							walk_n = diff_q[5:0];
							hdr_addr = 6'(depth_q - 7'd1);
							state_n = S_WALK;
						end
					end
					MODE_PUSH: begin
						if (top_q >= 9'(OperandDepth)) begin
							st_n = ST_OVER;
						end else begin
							opnd_we = 1'b1;
							top_n = top_q + 9'd1;
						end
					end
					MODE_POP: begin
						if (top_q == 9'd0) begin
							st_n = ST_UNDER;
						end else begin
							opnd_addr = 8'(top_q - 9'd1);
							top_n = top_q - 9'd1;
							state_n = S_OPND;
						end
					end
					MODE_PEEK: begin
						if ({1'b0, pdep_q} >= top_q) begin
							st_n = ST_UNDER;
						end else begin
							opnd_addr = 8'(top_q - {1'b0, pdep_q} - 9'd1);
							state_n = S_OPND;
						end
					end
					MODE_RETURN: begin
						if (depth_q <= 7'd1) begin
							st_n = ST_UNDER;
						end else begin
							hdr_addr = 6'(depth_q - 7'd1);
							state_n = S_RET;
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (walk_q == 6'd0) begin
					state_n = S_FIN;
					if (mode_q == MODE_CALL) begin
						hdr_addr = 6'(depth_q);
						hdr_we = 1'b1;
						hdr_wdata = '{level: hdr_rdata.level + 6'd1,
							static_link: {1'b0, idx_q}, dynamic_link: depth_q - 7'd1,
							ret: {1'b0, ret_q}, size: '0, base: top_q - args_q};
						row_clr = 1'b1;
						row_idx = 6'(depth_q);
						depth_n = depth_q + 7'd1;
					end else if (off_q < 7'(HeaderSize) || off_q >= hdr_rdata.size
							|| off_q >= 7'(MaxSlots)) begin
						st_n = ST_INVALID;
					end else begin
						slot_we = (mode_q == MODE_WRITE);
						state_n = S_MARK;
					end
				end else if (hdr_rdata.static_link[6] || hdr_rdata.static_link >= depth_q) begin
					st_n = ST_CORRUPT;
					state_n = S_FIN;
				end else begin
					idx_n = hdr_rdata.static_link[5:0];
					hdr_addr = hdr_rdata.static_link[5:0];
					walk_n = walk_q - 6'd1;
				end
			end
			S_MARK: begin
				state_n = S_FIN;
				if (mode_q == MODE_WRITE) begin
					mark_we = 1'b1;
					row_set = 1'b1;
				end else if (!mark_row[off_q[5:0]]) begin
					st_n = ST_INVALID;
				end else begin
					dout_n = slot_rdata;
				end
			end
			S_OPND: begin
				dout_n = opnd_rdata;
				state_n = S_FIN;
			end
			S_RES: begin
				state_n = S_FIN;
				if (hdr_rdata.size != 7'd0) begin
					st_n = ST_CORRUPT;
				end else begin
					hdr_addr = 6'(depth_q - 7'd1);
					hdr_we = 1'b1;
					hdr_wdata.size = cnt_q;
				end
			end
			S_RET: begin
				state_n = S_FIN;
				if (hdr_rdata.dynamic_link != depth_q - 7'd2) begin
					st_n = ST_CORRUPT;
				end else begin
					depth_n = depth_q - 7'd1;
					pf_n = 6'(depth_q - 7'd1);
					popped_n = 1'b1;
				end
			end
			S_FIN: begin
				hdr_addr = popped_q ? pf_q : 6'(depth_q - 7'd1);
				have_n = popped_q || (depth_q != 7'd0);
				state_n = S_LOAD;
			end
			S_LOAD: begin
				hdr_addr = popped_q ? pf_q : 6'(depth_q - 7'd1);
				if (load_en) begin
					state_n = S_IDLE;
				end
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			limit_q <= 7'(MaxFrames);
			depth_q <= '0;
			top_q <= '0;
			row_ok_q <= '0;
			out_valid_q <= 1'b0;
			popped_q <= 1'b0;
			have_q <= 1'b0;
			st_q <= ST_OK;
		end else begin
			state_q <= state_n;
			depth_q <= depth_n;
			top_q <= top_n;
			popped_q <= popped_n;
			have_q <= have_n;
			st_q <= st_n;
			if (psel && penable && pwrite && paddr == 3'd0) begin
				limit_q <= pwdata[6:0];
			end
			if (row_clr) begin
				row_ok_q[row_idx] <= 1'b0;
			end
			if (row_set) begin
				row_ok_q[row_idx] <= 1'b1;
			end
			if (load_en) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		dout_q <= dout_n;
		idx_q <= idx_n;
		walk_q <= walk_n;
		pf_q <= pf_n;
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			mode_q <= mode;
			diff_q <= level_difference;
			off_q <= slot_offset;
			cnt_q <= slot_count;
			data_q <= data_in;
			ret_q <= return_address;
			args_q <= argument_count;
			pdep_q <= peek_depth;
		end
		if (load_en) begin
			status <= st_q;
			data_out <= dout_q;
			frames_in_use <= depth_q;
			operands_in_use <= top_q;
			frame_return_address <= have_q ? hdr_rdata.ret : '0;
			frame_operand_base <= have_q ? hdr_rdata.base : '0;
			frame_lexical_level <= have_q ? hdr_rdata.level : '0;
			frame_static_link <= have_q ? hdr_rdata.static_link : '0;
			frame_dynamic_link <= have_q ? hdr_rdata.dynamic_link : '0;
			frame_slot_count <= have_q ? hdr_rdata.size : '0;
		end
	end
endmodule
`default_nettype wire
